### rtl/core/bri_pkg.sv
// Shared types and constants of the block rotate insert engine.
package bri_pkg;

	localparam int BRI_MEM_DEPTH  = 256;
	localparam int BRI_WORD_WIDTH = 32;

	localparam int FUNC_W  = 2;
	localparam int ADDR_W  = 8;
	localparam int DATA_W  = 32;
	localparam int SRC_W   = 8;
	localparam int DST_W   = 9;
	localparam int LEN_W   = 9;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_ROTATE = 2'd2
	} bri_func_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDWAIT,
		S_LEAD,
		S_LEADW,
		S_STEP,
		S_MOVE,
		S_DONE
	} bri_state_t;

	// decoded command flags
	typedef struct packed {
		logic ok;
		logic write_go;
		logic read_go;
		logic rot_go;
	} bri_cmd_t;

endpackage

### rtl/core/bri_cmd_if.sv
// Command channel: one word per access or rotate request.
interface bri_cmd_if;
	import bri_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ADDR_W-1:0] word_address;
	logic [DATA_W-1:0] write_data;
	logic [SRC_W-1:0]  src_index;
	logic [DST_W-1:0]  dst_index;
	logic [LEN_W-1:0]  move_length;

	modport source (
		output valid, func, word_address, write_data, src_index, dst_index, move_length,
		input  ready
	);
	modport sink (
		input  valid, func, word_address, write_data, src_index, dst_index, move_length,
		output ready
	);
endinterface

### rtl/core/bri_res_if.sv
// Result channel: one word per command.
interface bri_res_if;
	import bri_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              ok;

	modport source (
		output valid, read_data, ok,
		input  ready
	);
	modport sink (
		input  valid, read_data, ok,
		output ready
	);
endinterface

### rtl/core/block_rotate_insert_engine.sv
// Top level of the block rotate insert engine.
// Word memory of MEM_DEPTH entries with write, read and in-place block rotate commands.
// One command is in work at a time; the result register lets the next command in while
// a result waits. A rotate over a region of n words with shift k moves each word once,
// by a read and a write on the single RAM, and reads the leader of each permutation cycle
// first. Rejected rotates and a rotate whose block already sits before dst move nothing
// and go straight to the result.
// The RAM is not cleared; a word must be written before it is read.
module block_rotate_insert_engine #(
	parameter int MEM_DEPTH  = bri_pkg::BRI_MEM_DEPTH,
	parameter int WORD_WIDTH = bri_pkg::BRI_WORD_WIDTH
) (
	input logic       clk,
	input logic       arst_n,
	bri_cmd_if.sink   cmd,
	bri_res_if.source res
);
	import bri_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);

	bri_cmd_t              dec;
	logic [AW-1:0]         lo;
	logic [AW:0]           n, k;
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

	bri_decode #(.MEM_DEPTH(MEM_DEPTH)) u_decode (
		.func         (cmd.func),
		.word_address (cmd.word_address),
		.src_index    (cmd.src_index),
		.dst_index    (cmd.dst_index),
		.move_length  (cmd.move_length),
		.cmd          (dec),
		.lo           (lo),
		.n            (n),
		.k            (k)
	);

	bri_ctrl #(.MEM_DEPTH(MEM_DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (cmd.valid),
		.in_ready      (cmd.ready),
		.cmd           (dec),
		.lo            (lo),
		.n             (n),
		.k             (k),
		.word_address  (cmd.word_address),
		.write_data    (cmd.write_data),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.out_valid     (res.valid),
		.out_ready     (res.ready),
		.out_read_data (res.read_data),
		.out_ok        (res.ok)
	);

	bri_ram #(.WIDTH(WORD_WIDTH), .DEPTH(MEM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule

### rtl/core/bri_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module bri_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/core/bri_decode.sv
// Command decode: range checks and rotate region setup.
module bri_decode #(
	parameter int MEM_DEPTH = bri_pkg::BRI_MEM_DEPTH
) (
	input  logic [bri_pkg::FUNC_W-1:0]      func,
	input  logic [bri_pkg::ADDR_W-1:0]      word_address,
	input  logic [bri_pkg::SRC_W-1:0]       src_index,
	input  logic [bri_pkg::DST_W-1:0]       dst_index,
	input  logic [bri_pkg::LEN_W-1:0]       move_length,
	output bri_pkg::bri_cmd_t               cmd,
	output logic [$clog2(MEM_DEPTH)-1:0]    lo,
	output logic [$clog2(MEM_DEPTH):0]      n,
	output logic [$clog2(MEM_DEPTH):0]      k
);
	import bri_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int PW = AW + 1;
	localparam int CW = (AW + 2 > 11) ? AW + 2 : 11;

	logic [CW-1:0] addr_w, src_w, dst_w, len_w, end_w, depth_w;
	logic [CW-1:0] lo_w, n_w, k_w;
	logic          addr_ok, rot_ok, ident;

	assign addr_w  = CW'(word_address);
	assign src_w   = CW'(src_index);
	assign dst_w   = CW'(dst_index);
	assign len_w   = CW'(move_length);
	assign end_w   = src_w + len_w;
	assign depth_w = CW'(MEM_DEPTH);

	assign addr_ok = addr_w < depth_w;
	assign rot_ok  = (len_w != '0) && (src_w != dst_w)
		&& !((dst_w > src_w) && (dst_w < end_w))
		&& (end_w <= depth_w) && (dst_w <= depth_w);

	always_comb begin
		if (dst_w < src_w) begin
			lo_w = dst_w;
			n_w  = end_w - dst_w;
			k_w  = n_w - len_w;
		end else begin
			lo_w = src_w;
			n_w  = dst_w - src_w;
			k_w  = len_w;
		end
	end

	// block already sits right before dst: nothing moves
	assign ident = (k_w == n_w);

	assign lo = lo_w[AW-1:0];
	assign n  = n_w[PW-1:0];
	assign k  = k_w[PW-1:0];

	always_comb begin
		cmd = '0;
		case (func)
			FUNC_WRITE: begin
				cmd.ok       = addr_ok;
				cmd.write_go = addr_ok;
			end
			FUNC_READ: begin
				cmd.ok      = addr_ok;
				cmd.read_go = addr_ok;
			end
			FUNC_ROTATE: begin
				cmd.ok     = rot_ok;
				cmd.rot_go = rot_ok && !ident;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule

### rtl/core/bri_ctrl.sv
// Sequencer: word access, cycle-leader rotate over the RAM, result register.
module bri_ctrl #(
	parameter int MEM_DEPTH  = bri_pkg::BRI_MEM_DEPTH,
	parameter int WORD_WIDTH = bri_pkg::BRI_WORD_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bri_pkg::bri_cmd_t               cmd,
	input  logic [$clog2(MEM_DEPTH)-1:0]    lo,
	input  logic [$clog2(MEM_DEPTH):0]      n,
	input  logic [$clog2(MEM_DEPTH):0]      k,
	input  logic [bri_pkg::ADDR_W-1:0]      word_address,
	input  logic [bri_pkg::DATA_W-1:0]      write_data,
	output logic                            ram_we,
	output logic [$clog2(MEM_DEPTH)-1:0]    ram_waddr,
	output logic [WORD_WIDTH-1:0]           ram_wdata,
	output logic                            ram_re,
	output logic [$clog2(MEM_DEPTH)-1:0]    ram_raddr,
	input  logic [WORD_WIDTH-1:0]           ram_rdata,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bri_pkg::DATA_W-1:0]      out_read_data,
	output logic                            out_ok
);
	import bri_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int PW = AW + 1;

	bri_state_t state_q, state_d;

	logic [AW-1:0]     lo_q;
	logic [PW-1:0]     n_q, k_q, c_q, j_q, nxt_q, cnt_q;
	logic [WORD_WIDTH-1:0] tmp_q;
	logic [DATA_W-1:0] res_data_q;
	logic              res_ok_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_ok_q;

	logic                     acc, out_load, close, last;
	logic [PW:0]              sum;
	logic [PW-1:0]            nxt, cnt_inc, c_inc;
	logic [AW+ADDR_W-1:0]     addr_ext;
	logic [WORD_WIDTH+DATA_W-1:0] wd_ext, rd_ext;

	assign acc      = in_valid && in_ready;
	assign addr_ext = {AW'(0), word_address};
	assign wd_ext   = {WORD_WIDTH'(0), write_data};
	assign rd_ext   = {DATA_W'(0), ram_rdata};

	// next position in the cycle: (j + k) mod n, with j, k < n
	assign sum     = {1'b0, j_q} + {1'b0, k_q};
	assign nxt     = (sum >= {1'b0, n_q}) ? PW'(sum - {1'b0, n_q}) : sum[PW-1:0];
	assign close   = (nxt == c_q);
	assign cnt_inc = cnt_q + PW'(1);
	assign c_inc   = c_q + PW'(1);
	assign last    = (cnt_inc == n_q);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (cmd.read_go) begin
						state_d = S_RDWAIT;
					end else if (cmd.rot_go) begin
						state_d = S_LEAD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_RDWAIT: state_d = S_DONE;
			S_LEAD:   state_d = S_LEADW;
			S_LEADW:  state_d = S_STEP;
			S_STEP: begin
				if (!close) begin
					state_d = S_MOVE;
				end else if (last) begin
					state_d = S_DONE;
				end else begin
					state_d = S_LEAD;
				end
			end
			S_MOVE:   state_d = S_STEP;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		ram_we    = 1'b0;
		ram_waddr = lo_q + j_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = lo_q + c_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				ram_we    = acc && cmd.write_go;
				ram_waddr = addr_ext[AW-1:0];
				ram_wdata = wd_ext[WORD_WIDTH-1:0];
				ram_re    = acc && cmd.read_go;
				ram_raddr = addr_ext[AW-1:0];
			end
			S_LEAD: begin
				ram_re = 1'b1;
			end
			S_STEP: begin
				if (close) begin
					ram_we    = 1'b1;
					ram_wdata = tmp_q;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = lo_q + nxt[AW-1:0];
				end
			end
			S_MOVE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_data_q;
			out_ok_q   <= res_ok_q;
		end
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					lo_q       <= lo;
					n_q        <= n;
					k_q        <= k;
					c_q        <= '0;
					j_q        <= '0;
					cnt_q      <= '0;
					res_ok_q   <= cmd.ok;
					res_data_q <= '0;
				end
			end
			S_RDWAIT: res_data_q <= rd_ext[DATA_W-1:0];
			S_LEADW:  tmp_q <= ram_rdata;
			S_STEP: begin
				if (close) begin
					cnt_q <= cnt_inc;
					c_q   <= c_inc;
					j_q   <= c_inc;
				end else begin
					nxt_q <= nxt;
				end
			end
			S_MOVE: begin
				j_q   <= nxt_q;
				cnt_q <= cnt_inc;
			end
			default: begin
				tmp_q <= tmp_q;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign out_read_data = out_data_q;
	assign out_ok        = out_ok_q;
endmodule

### rtl/core/bri_chk.sv
// Port-level checks of the block rotate insert engine, bound to the top level.
module bri_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_read_data,
	input logic        res_ok
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_read_data) && $stable(res_ok))
		else $error("result word changed while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ok |-> res_read_data == 32'd0)
		else $error("rejected command carries data");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one in work");
endmodule

bind block_rotate_insert_engine bri_chk u_bri_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_read_data (res.read_data),
	.res_ok        (res.ok)
);
